[hdl/linear_probe_hash_table_core_assert.svh]
// Assertion macros for the linear probe hash table core
`ifndef LINEAR_PROBE_HASH_TABLE_CORE_ASSERT_SVH
`define LINEAR_PROBE_HASH_TABLE_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// ante holds in a cycle -> cons holds in the same cycle
`define LPHT_ASSERT_IMP(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lpht assertion failed");

// ante holds in a cycle -> cons holds in the next cycle
`define LPHT_ASSERT_NXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lpht assertion failed");

`else

`define LPHT_ASSERT_IMP(name, ante, cons)
`define LPHT_ASSERT_NXT(name, ante, cons)

`endif

`endif

[hdl/lpht_pkg.sv]
// Types and constants of the linear probe hash table
`default_nettype none

package lpht_pkg;

   localparam int TableDepthDefault = 1024;
   localparam int ValueWidthDefault = 32;

   localparam int KeyWidth    = 32;
   localparam int DataWidth   = 32;
   localparam int BucketWidth = 11;
   localparam int EntryWidth  = 11;
   localparam int OpWidth     = 2;
   localparam int StatusWidth = 2;

   localparam logic [BucketWidth-1:0] BucketReset = BucketWidth'(1021);

   // remainder bits resolved per divide cycle
   localparam int DigitsPerStep = 4;
   localparam int StepCount     = KeyWidth / DigitsPerStep;

   localparam logic [OpWidth-1:0] OP_PUT    = 2'd0;
   localparam logic [OpWidth-1:0] OP_GET    = 2'd1;
   localparam logic [OpWidth-1:0] OP_REMOVE = 2'd2;

   localparam logic [StatusWidth-1:0] STATUS_OK      = 2'd0;
   localparam logic [StatusWidth-1:0] STATUS_REFUSED = 2'd1;
   localparam logic [StatusWidth-1:0] STATUS_MISSING = 2'd2;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIVIDE,
      ST_READ,
      ST_CHECK,
      ST_REPLY
   } state_type;

endpackage

`default_nettype wire

[hdl/lpht_ram.sv]
// Generic simple dual port RAM with registered read
`default_nettype none

module lpht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

[hdl/linear_probe_hash_table_core.sv]
// Top level of the linear probe hash table core
`default_nettype none

`include "linear_probe_hash_table_core_assert.svh"

// Open-addressing hash table with linear probing and tombstones, one word at a
// time. An accepted put, get or remove is taken in, forms the home slot
// |key| mod bucket_count (a restoring divider resolving 4 remainder bits per
// cycle), probes slot by slot (registered read of the slot RAM, then check
// and write back), and then loads the result register; the reply waits while
// the previous result word is still held. A refused put and an unknown
// operation go straight to the reply. After reset the block runs a clearing
// pass over the slot RAM before it takes its first word; bucket count writes
// are taken throughout.
module linear_probe_hash_table_core #(
   parameter int TABLE_DEPTH = lpht_pkg::TableDepthDefault,
   parameter int VALUE_WIDTH = lpht_pkg::ValueWidthDefault
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [lpht_pkg::OpWidth-1:0]      req_operation,
   input  wire logic signed [lpht_pkg::KeyWidth-1:0] req_key,
   input  wire logic [lpht_pkg::DataWidth-1:0]    req_value,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [lpht_pkg::StatusWidth-1:0]       rsp_status,
   output logic [lpht_pkg::DataWidth-1:0]         rsp_found_value,
   input  wire logic                              csr_write_enable,
   input  wire logic [lpht_pkg::BucketWidth-1:0]  csr_bucket_count
);

   import lpht_pkg::*;

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int LW = (AW + 1 > BucketWidth) ? AW + 1 : BucketWidth;
   localparam int CW = (LW > EntryWidth + 1) ? LW : EntryWidth + 1;
   localparam int RW = 2 + KeyWidth + VALUE_WIDTH;
   localparam int SW = $clog2(StepCount);

   state_type                state_ff, state_in;
   logic [AW-1:0]            clr_addr_ff, clr_addr_in;
   logic [BucketWidth-1:0]   bucket_ff, bucket_in;
   logic [EntryWidth-1:0]    entry_count_ff, entry_count_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   logic [OpWidth-1:0]       op_ff, op_in;
   logic [KeyWidth-1:0]      key_ff, key_in;
   logic [VALUE_WIDTH-1:0]   val_ff, val_in;
   logic [KeyWidth-1:0]      dvd_ff, dvd_in;
   logic [LW-1:0]            rem_ff, rem_in;
   logic [SW-1:0]            step_ff, step_in;
   logic [AW-1:0]            pos_ff, pos_in;
   logic [LW-1:0]            probes_ff, probes_in;
   logic [StatusWidth-1:0]   status_ff, status_in;
   logic [DataWidth-1:0]     found_ff, found_in;
   logic [StatusWidth-1:0]   rsp_status_ff, rsp_status_in;
   logic [DataWidth-1:0]     rsp_found_ff, rsp_found_in;

   logic [LW-1:0]            live;
   logic [LW-1:0]            bucket_wide;
   logic [KeyWidth-1:0]      mag;
   logic [LW-1:0]            r_work;
   logic [KeyWidth-1:0]      d_work;
   logic [LW:0]              r_trial;
   logic [63:0]              req_value_wide;
   logic [63:0]              rd_value_wide;

   logic                     ram_wr_en;
   logic [AW-1:0]            ram_wr_addr;
   logic [RW-1:0]            ram_wr_data;
   logic [RW-1:0]            ram_rd_data;
   logic                     rd_tomb;
   logic                     rd_used;
   logic [KeyWidth-1:0]      rd_key;
   logic [VALUE_WIDTH-1:0]   rd_val;
   logic [LW-1:0]            pos_next;
   logic                     probe_last;
   logic                     half_full;

   lpht_ram #(
      .WIDTH(RW),
      .DEPTH(TABLE_DEPTH)
   ) u_slots (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_addr(pos_ff),
      .rd_data(ram_rd_data)
   );

   assign {rd_tomb, rd_used, rd_key, rd_val} = ram_rd_data;
   assign rd_value_wide = 64'(rd_val);
   assign req_value_wide = 64'(req_value);

   // zero acts as one, anything above the RAM depth as the depth
   assign bucket_wide = LW'(bucket_ff);
   always_comb begin
      if (bucket_ff == '0) begin
         live = LW'(1);
      end else if (bucket_wide > LW'(TABLE_DEPTH)) begin
         live = LW'(TABLE_DEPTH);
      end else begin
         live = bucket_wide;
      end
   end

   // two's complement negate also gives 2^31 for the minimum key
   assign mag = req_key[KeyWidth-1] ? (~req_key + KeyWidth'(1)) : req_key;

   assign half_full = ({{(CW-EntryWidth){1'b0}}, entry_count_ff} << 1) > CW'(live);
   assign pos_next = LW'(pos_ff) + LW'(1);
   assign probe_last = (probes_ff + LW'(1)) == live;

   // remainder digits for one divide cycle
   always_comb begin
      r_work = rem_ff;
      d_work = dvd_ff;
      r_trial = '0;
      for (int i = 0; i < DigitsPerStep; i++) begin
         r_trial = {r_work, d_work[KeyWidth-1]};
         d_work = {d_work[KeyWidth-2:0], 1'b0};
         if (r_trial >= {1'b0, live}) begin
            r_trial = r_trial - {1'b0, live};
         end
         r_work = r_trial[LW-1:0];
      end
   end

   always_comb begin
      state_in       = state_ff;
      clr_addr_in    = clr_addr_ff;
      bucket_in      = bucket_ff;
      entry_count_in = entry_count_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      op_in          = op_ff;
      key_in         = key_ff;
      val_in         = val_ff;
      dvd_in         = dvd_ff;
      rem_in         = rem_ff;
      step_in        = step_ff;
      pos_in         = pos_ff;
      probes_in      = probes_ff;
      status_in      = status_ff;
      found_in       = found_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_found_in   = rsp_found_ff;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = pos_ff;
      ram_wr_data    = '0;
      req_ready      = 1'b0;

      if (csr_write_enable) begin
         bucket_in = csr_bucket_count;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_addr_ff;
            clr_addr_in = clr_addr_ff + AW'(1);
            if (clr_addr_ff == AW'(TABLE_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in     = req_operation;
               key_in    = req_key;
               val_in    = req_value_wide[VALUE_WIDTH-1:0];
               dvd_in    = mag;
               rem_in    = '0;
               step_in   = '0;
               probes_in = '0;
               found_in  = '0;
               status_in = STATUS_OK;
               if (req_operation == OP_PUT && half_full) begin
                  status_in = STATUS_REFUSED;
                  state_in  = ST_REPLY;
               end else if (req_operation == OP_PUT || req_operation == OP_GET ||
                            req_operation == OP_REMOVE) begin
                  state_in = ST_DIVIDE;
               end else begin
                  state_in = ST_REPLY;
               end
            end
         end
         ST_DIVIDE: begin
            rem_in  = r_work;
            dvd_in  = d_work;
            step_in = step_ff + SW'(1);
            if (step_ff == SW'(StepCount - 1)) begin
               pos_in   = r_work[AW-1:0];
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            state_in = ST_REPLY;
            case (op_ff)
               OP_PUT: begin
                  if (!rd_used) begin
                     ram_wr_en      = 1'b1;
                     ram_wr_data    = {rd_tomb, 1'b1, key_ff, val_ff};
                     entry_count_in = entry_count_ff + EntryWidth'(1);
                  end else if (probe_last) begin
                     status_in = STATUS_REFUSED;
                  end else begin
                     state_in = ST_READ;
                  end
               end
               default: begin
                  if (!rd_used && !rd_tomb) begin
                     status_in = STATUS_MISSING;
                  end else if (rd_used && rd_key == key_ff) begin
                     if (op_ff == OP_GET) begin
                        found_in = rd_value_wide[DataWidth-1:0];
                     end else begin
                        ram_wr_en   = 1'b1;
                        ram_wr_data = {1'b1, 1'b0, rd_key, rd_val};
                        if (entry_count_ff != '0) begin
                           entry_count_in = entry_count_ff - EntryWidth'(1);
                        end
                     end
                  end else if (probe_last) begin
                     status_in = STATUS_MISSING;
                  end else begin
                     state_in = ST_READ;
                  end
               end
            endcase
            if (state_in == ST_READ) begin
               probes_in = probes_ff + LW'(1);
               pos_in    = (pos_next == live) ? '0 : pos_next[AW-1:0];
            end
         end
         ST_REPLY: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_found_in  = found_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clr_addr_ff    <= '0;
         bucket_ff      <= BucketReset;
         entry_count_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         clr_addr_ff    <= clr_addr_in;
         bucket_ff      <= bucket_in;
         entry_count_ff <= entry_count_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      val_ff        <= val_in;
      dvd_ff        <= dvd_in;
      rem_ff        <= rem_in;
      step_ff       <= step_in;
      pos_ff        <= pos_in;
      probes_ff     <= probes_in;
      status_ff     <= status_in;
      found_ff      <= found_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found_value = rsp_found_ff;

   `LPHT_ASSERT_NXT(a_check_after_read, state_ff == ST_READ, state_ff == ST_CHECK)
   `LPHT_ASSERT_IMP(a_probe_in_range, state_ff == ST_READ, LW'(pos_ff) < live)
   `LPHT_ASSERT_IMP(a_write_source, ram_wr_en, state_ff == ST_CLEAR || state_ff == ST_CHECK)
   `LPHT_ASSERT_IMP(a_count_bound, 1'b1, int'(entry_count_ff) <= TABLE_DEPTH)

endmodule

`default_nettype wire

[bench/testbench.sv]
// Self-checking testbench for the linear probe hash table core
`timescale 1ns / 100ps
`default_nettype none

module testbench;
   import lpht_pkg::*;

   localparam int Depth = 1024;

   typedef struct packed {
      logic [OpWidth-1:0]   operation;
      logic [KeyWidth-1:0]  key;
      logic [DataWidth-1:0] value;
   } request_type;

   typedef struct packed {
      logic [StatusWidth-1:0] status;
      logic [DataWidth-1:0]   found_value;
   } reply_type;

   localparam logic [OpWidth-1:0] OP_UNKNOWN = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [OpWidth-1:0] req_operation = OP_PUT;
   logic signed [KeyWidth-1:0] req_key = '0;
   logic [DataWidth-1:0] req_value = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [StatusWidth-1:0] rsp_status;
   logic [DataWidth-1:0] rsp_found_value;
   logic csr_write_enable = 1'b0;
   logic [BucketWidth-1:0] csr_bucket_count = '0;

   linear_probe_hash_table_core dut (
      .clock, .reset, .req_valid, .req_ready, .req_operation, .req_key, .req_value,
      .rsp_valid, .rsp_ready, .rsp_status, .rsp_found_value,
      .csr_write_enable, .csr_bucket_count
   );

   // table mirror
   bit              mirror_used [Depth];
   bit              mirror_tomb [Depth];
   logic [31:0]     mirror_key [Depth];
   logic [31:0]     mirror_value [Depth];
   int unsigned     mirror_entries;
   int unsigned     mirror_buckets;

   request_type pending_words[$];
   reply_type   expected_replies[$];
   int          mismatch_count;
   bit          hold_off_active = 1'b0;
   int          send_gap;
   int          recv_gap;
   bit          driving_enabled;

   // keys recently put, so gets and removes often hit
   logic [31:0] known_keys[$];

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic int unsigned live_bucket_count();
      if (mirror_buckets == 0) return 1;
      if (mirror_buckets > Depth) return Depth;
      return mirror_buckets;
   endfunction

   function automatic int unsigned home_of(logic [31:0] key_bits, int unsigned buckets);
      logic [31:0] negated;
      logic [32:0] magnitude;
      negated = ~key_bits + 32'd1;
      magnitude = key_bits[31] ? {1'b0, negated} : {1'b0, key_bits};
      if (key_bits == 32'h8000_0000) magnitude = 33'h0_8000_0000;
      return int'(magnitude % 33'(buckets));
   endfunction

   function automatic int lookup_slot(logic [31:0] key_bits, int unsigned buckets);
      int unsigned pos;
      pos = home_of(key_bits, buckets);
      for (int unsigned n = 0; n < buckets; n++) begin
         if (!mirror_used[pos] && !mirror_tomb[pos]) break;
         if (mirror_used[pos] && mirror_key[pos] == key_bits) return int'(pos);
         pos = (pos + 1 == buckets) ? 0 : pos + 1;
      end
      return -1;
   endfunction

   function automatic reply_type apply_request(request_type w);
      reply_type r;
      int unsigned buckets;
      int unsigned pos;
      int hit;
      bit placed;
      buckets = live_bucket_count();
      r = '{status: STATUS_OK, found_value: '0};
      case (w.operation)
         OP_PUT: begin
            if (mirror_entries * 2 > buckets) begin
               r.status = STATUS_REFUSED;
            end else begin
               pos = home_of(w.key, buckets);
               placed = 1'b0;
               for (int unsigned n = 0; n < buckets && !placed; n++) begin
                  if (!mirror_used[pos]) begin
                     mirror_used[pos] = 1'b1;
                     mirror_key[pos] = w.key;
                     mirror_value[pos] = w.value;
                     mirror_entries++;
                     placed = 1'b1;
                  end else begin
                     pos = (pos + 1 == buckets) ? 0 : pos + 1;
                  end
               end
               if (!placed) r.status = STATUS_REFUSED;
            end
         end
         OP_GET: begin
            hit = lookup_slot(w.key, buckets);
            if (hit < 0) r.status = STATUS_MISSING;
            else r.found_value = mirror_value[hit];
         end
         OP_REMOVE: begin
            hit = lookup_slot(w.key, buckets);
            if (hit < 0) begin
               r.status = STATUS_MISSING;
            end else begin
               mirror_used[hit] = 1'b0;
               mirror_tomb[hit] = 1'b1;
               if (mirror_entries > 0) mirror_entries--;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic int draw_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      if (pick < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // driver: offers words from the pending queue
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            expected_replies.push_back(apply_request(
               '{operation: req_operation, key: req_key, value: req_value}));
         end
         if (send_gap > 0 && !(req_valid && !req_ready)) begin
            send_gap <= send_gap - 1;
            if (req_valid && req_ready) req_valid <= 1'b0;
         end else if (!req_valid || req_ready) begin
            if (driving_enabled && pending_words.size() > 0) begin
               req_valid <= 1'b1;
               req_operation <= pending_words[0].operation;
               req_key <= pending_words[0].key;
               req_value <= pending_words[0].value;
               void'(pending_words.pop_front());
               send_gap <= draw_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: checks results against the mirror and throttles ready
   always @(posedge clock) begin
      reply_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_replies.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected result word: status %0d value %h",
                     rsp_status, rsp_found_value);
            end else begin
               want = expected_replies.pop_front();
               if (want.status !== rsp_status || want.found_value !== rsp_found_value) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("result mismatch: expected status %0d value %h, got %0d %h",
                        want.status, want.found_value, rsp_status, rsp_found_value);
               end
            end
         end
         if (hold_off_active) begin
            rsp_ready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (rsp_valid && rsp_ready) recv_gap <= draw_gap();
         end
      end
   end

   // receiver hold-off, run as a process of its own
   task automatic hold_receiver(int cycles);
      hold_off_active <= 1'b1;
      repeat (cycles) @(posedge clock);
      hold_off_active <= 1'b0;
   endtask

   task automatic queue_word(logic [OpWidth-1:0] op, logic [31:0] key_bits,
         logic [31:0] value);
      pending_words.push_back('{operation: op, key: key_bits, value: value});
      if (op == OP_PUT) begin
         known_keys.push_back(key_bits);
         if (known_keys.size() > 48) void'(known_keys.pop_front());
      end
   endtask

   task automatic wait_drained();
      while (pending_words.size() > 0 || req_valid || expected_replies.size() > 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic set_buckets(logic [BucketWidth-1:0] count);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_bucket_count <= count;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      mirror_buckets = count;
   endtask

   function automatic logic [31:0] random_key(int unsigned buckets);
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 45 && known_keys.size() > 0)
         return known_keys[$urandom_range(0, known_keys.size() - 1)];
      if (pick < 70) return 32'($urandom_range(0, 3 * buckets)) * (pick[0] ? 1 : -1);
      if (pick < 75) return pick[0] ? 32'h8000_0000 : 32'h7fff_ffff;
      return $urandom;
   endfunction

   task automatic queue_random(int count, int unsigned buckets);
      int pick;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) queue_word(OP_PUT, random_key(buckets), $urandom);
         else if (pick < 75) queue_word(OP_GET, random_key(buckets), $urandom);
         else if (pick < 97) queue_word(OP_REMOVE, random_key(buckets), $urandom);
         else queue_word(OP_UNKNOWN, $urandom, $urandom);
      end
   endtask

   initial begin
      int unsigned sizes[6];
      mirror_buckets = 1021;
      mirror_entries = 0;
      mismatch_count = 0;
      send_gap = 0;
      recv_gap = 0;
      driving_enabled = 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, all operations, duplicates, missing keys
      queue_word(OP_GET, 32'd5, 32'hffff_ffff);
      queue_word(OP_REMOVE, 32'd5, '0);
      queue_word(OP_PUT, 32'h8000_0000, 32'hffff_ffff);
      queue_word(OP_PUT, 32'h7fff_ffff, 32'h0000_0000);
      queue_word(OP_PUT, 32'hffff_ffff, 32'h5555_aaaa);
      queue_word(OP_PUT, 32'd1, 32'haaaa_5555);
      queue_word(OP_PUT, 32'd1, 32'h1234_5678);
      queue_word(OP_PUT, 32'd0, 32'h0000_0001);
      queue_word(OP_GET, 32'h8000_0000, '0);
      queue_word(OP_GET, 32'h7fff_ffff, '0);
      queue_word(OP_GET, 32'hffff_ffff, '0);
      queue_word(OP_GET, 32'd1, '0);
      queue_word(OP_REMOVE, 32'd1, '0);
      queue_word(OP_GET, 32'd1, '0);
      queue_word(OP_REMOVE, 32'd1, '0);
      queue_word(OP_REMOVE, 32'd1, '0);
      queue_word(OP_PUT, 32'd1, 32'hdead_beef);
      queue_word(OP_GET, 32'd1, '0);
      queue_word(OP_UNKNOWN, 32'hffff_ffff, 32'hffff_ffff);
      queue_word(OP_GET, 32'd1022, '0);
      wait_drained();

      // long receiver hold-off while the sender keeps offering
      fork
         hold_receiver(400);
      join_none
      queue_random(60, 1021);
      wait_drained();

      // small tables fill quickly; lowering the count strands entries
      sizes = '{0, 1, 2, 7, 1024, 2047};
      foreach (sizes[s]) begin
         set_buckets(BucketWidth'(sizes[s]));
         queue_random(sizes[s] > 7 ? 170 : 90, live_bucket_count());
         wait_drained();
      end
      set_buckets(BucketWidth'(13));
      queue_random(120, 13);
      wait_drained();
      set_buckets(BucketWidth'(3));
      queue_random(60, 3);
      wait_drained();
      set_buckets(BucketWidth'(97));
      queue_random(150, 97);
      wait_drained();

      if (mismatch_count == 0 && expected_replies.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #200ms;
      $display("Verification failed");
      $finish;
   end

endmodule

`default_nettype wire
